// ----- rtl/cfcr_pkg.sv -----
// Shared types, constants and the CRC-8 byte update for the frame checker and responder.
// No dependencies; every other file but cfcr_ram imports this package.
package cfcr_pkg;

    // Result status codes
    localparam logic [1:0] ST_REPLY    = 2'd0;
    localparam logic [1:0] ST_CRC_ERR  = 2'd1;
    localparam logic [1:0] ST_ZERO_LEN = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] TYPE_REPLY_BIT = 8'h80;

    // Depth of the job queue between front and back
    localparam int QDEPTH = 2;

    // One job handed from front to back: a status-only result or a whole reply
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] preamble;
        logic [7:0] count;
        logic [7:0] type_out;
        logic [7:0] length;
        logic [7:0] crc;
    } t_job;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_qstat;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc_add(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/cfcr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cfcr_front.sv -----
// Front end: parses the incoming frame, runs both CRCs, stores payload, queues jobs.
// Depends on cfcr_pkg.
module cfcr_front import cfcr_pkg::*; #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_push,
    output logic                                                o_full,
    input  logic                                                i_func,
    input  logic [7:0]                                          i_rx_byte,
    input  t_qstat                                              i_qstat,
    input  logic                                                i_back_busy,
    output logic                                                o_job_push,
    output t_job                                                o_job,
    output logic                                                o_we,
    output logic [(MAX_PAYLOAD > 1 ? $clog2(MAX_PAYLOAD) : 1)-1:0] o_waddr,
    output logic [7:0]                                          o_wdata
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    localparam logic [2:0] PH_PRE = 3'd0;
    localparam logic [2:0] PH_CNT = 3'd1;
    localparam logic [2:0] PH_TYP = 3'd2;
    localparam logic [2:0] PH_LEN = 3'd3;
    localparam logic [2:0] PH_PAY = 3'd4;
    localparam logic [2:0] PH_CRC = 3'd5;

    logic [2:0]    r_phase, n_phase;
    logic [7:0]    r_check, n_check;
    logic [7:0]    r_reply, n_reply;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_pre, n_pre;
    logic [7:0]    r_cnt, n_cnt;
    logic [7:0]    r_typ, n_typ;
    logic [7:0]    r_len, n_len;
    logic          accept;
    logic [7:0]    check_nx;
    logic [CW-1:0] count_inc;

    // Hold input while the queue is full; payload also while the store is being read out
    assign o_full = i_qstat.full
                 || ((r_phase == PH_PAY) && (i_qstat.not_empty || i_back_busy));
    assign accept = i_push && !o_full;
    assign check_nx = crc_add(r_check, i_rx_byte);
    assign count_inc = r_count + CW'(1);

    assign o_waddr = r_count[AW-1:0];
    assign o_wdata = i_rx_byte;

    always_comb begin
        n_phase = r_phase;
        n_check = r_check;
        n_reply = r_reply;
        n_count = r_count;
        n_pre = r_pre;
        n_cnt = r_cnt;
        n_typ = r_typ;
        n_len = r_len;
        o_job_push = 1'b0;
        o_we = 1'b0;
        o_job = '{status: ST_REPLY, preamble: r_pre, count: r_cnt,
                  type_out: r_typ | TYPE_REPLY_BIT, length: r_len, crc: r_reply};
        if (accept) begin
            if (i_func) begin
                n_phase = PH_PRE;
                n_check = CRC_INIT;
                n_reply = CRC_INIT;
                n_count = '0;
            end else begin
                n_check = check_nx;
                unique case (r_phase)
                    PH_CNT: begin
                        n_cnt = i_rx_byte;
                        n_reply = crc_add(r_reply, i_rx_byte);
                        n_phase = PH_TYP;
                    end
                    PH_TYP: begin
                        n_typ = i_rx_byte;
                        n_reply = crc_add(r_reply, i_rx_byte | TYPE_REPLY_BIT);
                        n_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        n_len = i_rx_byte;
                        if (i_rx_byte == 8'd0 || i_rx_byte > MAX_LEN) begin
                            o_job_push = 1'b1;
                            o_job.status = (i_rx_byte == 8'd0) ? ST_ZERO_LEN : ST_TOO_LONG;
                            n_phase = PH_PRE;
                            n_check = CRC_INIT;
                            n_reply = CRC_INIT;
                        end else begin
                            n_reply = crc_add(r_reply, i_rx_byte);
                            n_phase = PH_PAY;
                        end
                        n_count = '0;
                    end
                    PH_PAY: begin
                        o_we = 1'b1;
                        n_reply = crc_add(r_reply, i_rx_byte);
                        n_count = count_inc;
                        if (8'(count_inc) >= r_len) begin
                            n_phase = PH_CRC;
                        end
                    end
                    PH_CRC: begin
                        o_job_push = 1'b1;
                        if (check_nx != 8'd0) begin
                            o_job.status = ST_CRC_ERR;
                        end
                        n_phase = PH_PRE;
                        n_check = CRC_INIT;
                        n_reply = CRC_INIT;
                        n_count = '0;
                    end
                    default: begin
                        // preamble, and unused codes taken as a fresh start
                        n_pre = i_rx_byte;
                        n_check = crc_add(CRC_INIT, i_rx_byte);
                        n_reply = crc_add(CRC_INIT, i_rx_byte);
                        n_count = '0;
                        n_phase = PH_CNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PRE;
            r_check <= CRC_INIT;
            r_reply <= CRC_INIT;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_check <= n_check;
            r_reply <= n_reply;
            r_count <= n_count;
        end
        r_pre <= n_pre;
        r_cnt <= n_cnt;
        r_typ <= n_typ;
        r_len <= n_len;
    end

endmodule

// ----- rtl/cfcr_queue.sv -----
// Short job queue between front and back.
// Depends on cfcr_pkg.
module cfcr_queue import cfcr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_job,
    output t_qstat o_qstat
);

    localparam int PW = $clog2(QDEPTH);
    localparam int NW = $clog2(QDEPTH + 1);

    t_job          r_mem [QDEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [NW-1:0] r_num, n_num;

    assign o_job = r_mem[r_rp];
    assign o_qstat.full = (r_num == NW'(QDEPTH));
    assign o_qstat.not_empty = (r_num != '0);

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        n_num = r_num;
        if (i_push) begin
            n_wp = (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_num = r_num + NW'(1);
        end else if (i_pop && !i_push) begin
            n_num = r_num - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_num <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_num <= n_num;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ----- rtl/cfcr_back.sv -----
// Back end: turns queued jobs into result words, reading payload from the store.
// Depends on cfcr_pkg.
module cfcr_back import cfcr_pkg::*; #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_job_valid,
    input  t_job                                                i_job,
    output logic                                                o_job_pop,
    output logic                                                o_busy,
    output logic                                                o_re,
    output logic [(MAX_PAYLOAD > 1 ? $clog2(MAX_PAYLOAD) : 1)-1:0] o_raddr,
    input  logic [7:0]                                          i_rdata,
    output logic                                                o_empty,
    input  logic                                                i_pop,
    output logic [7:0]                                          o_tx_byte,
    output logic                                                o_last,
    output logic [1:0]                                          o_status
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_STAT = 3'd1;
    localparam logic [2:0] B_HDR  = 3'd2;
    localparam logic [2:0] B_RD   = 3'd3;
    localparam logic [2:0] B_WR   = 3'd4;
    localparam logic [2:0] B_CRC  = 3'd5;

    logic [2:0]    r_state, n_state;
    t_job          r_job, n_job;
    logic [1:0]    r_hidx, n_hidx;
    logic [AW-1:0] r_pidx, n_pidx;
    logic          r_ovalid, n_ovalid;
    logic [7:0]    r_otx, n_otx;
    logic          r_olast, n_olast;
    logic [1:0]    r_ost, n_ost;
    logic          out_free;
    logic [7:0]    hdr_byte;

    assign out_free = !r_ovalid || i_pop;
    assign o_busy = (r_state != B_IDLE);
    assign o_job_pop = (r_state == B_IDLE) && i_job_valid;
    assign o_re = (r_state == B_RD);
    assign o_raddr = r_pidx;
    assign o_empty = !r_ovalid;
    assign o_tx_byte = r_otx;
    assign o_last = r_olast;
    assign o_status = r_ost;

    always_comb begin
        unique case (r_hidx)
            2'd0: hdr_byte = r_job.preamble;
            2'd1: hdr_byte = r_job.count;
            2'd2: hdr_byte = r_job.type_out;
            default: hdr_byte = r_job.length;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_job = r_job;
        n_hidx = r_hidx;
        n_pidx = r_pidx;
        n_ovalid = r_ovalid && !i_pop;
        n_otx = r_otx;
        n_olast = r_olast;
        n_ost = r_ost;
        unique case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    n_job = i_job;
                    n_hidx = '0;
                    n_pidx = '0;
                    n_state = (i_job.status == ST_REPLY) ? B_HDR : B_STAT;
                end
            end
            B_STAT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_otx = 8'd0;
                    n_olast = 1'b1;
                    n_ost = r_job.status;
                    n_state = B_IDLE;
                end
            end
            B_HDR: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_otx = hdr_byte;
                    n_olast = 1'b0;
                    n_ost = ST_REPLY;
                    n_hidx = r_hidx + 2'd1;
                    if (r_hidx == 2'd3) begin
                        n_state = B_RD;
                    end
                end
            end
            B_RD: begin
                n_state = B_WR;
            end
            B_WR: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_otx = i_rdata;
                    n_olast = 1'b0;
                    n_ost = ST_REPLY;
                    n_pidx = r_pidx + AW'(1);
                    n_state = ((8'(r_pidx) + 8'd1) == r_job.length) ? B_CRC : B_RD;
                end
            end
            B_CRC: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_otx = r_job.crc;
                    n_olast = 1'b1;
                    n_ost = ST_REPLY;
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_job <= n_job;
        r_hidx <= n_hidx;
        r_pidx <= n_pidx;
        r_otx <= n_otx;
        r_olast <= n_olast;
        r_ost <= n_ost;
    end

endmodule

// ----- rtl/crc8_frame_checker_responder_top.sv -----
// Top level of the CRC-8 framed packet checker and echo responder.
// Depends on cfcr_pkg, cfcr_ram, cfcr_front, cfcr_queue and cfcr_back.
//
//  Channel   Handshake             Word
//  -------   --------------------  ----------------------------------
//  input     push / full           i_func, i_rx_byte
//  result    empty / pop           o_tx_byte, o_last, o_status
//
// Flow: the front takes one input word per cycle while full is low. A reply
// of length L leaves as 4 header words, L payload words and 1 CRC word;
// each payload word takes a store read, then an output load. A status
// result passes through the job queue and a status state before it is loaded.
// Reset: synchronous, active low; parser, job queue and output flag clear,
// the payload store is not cleared (only entries of the current frame are read).
// Stalls: full rises when the job queue is full, and on payload bytes while
// a job waits in the queue or the back end is still busy. The result word
// holds until popped.
module crc8_frame_checker_responder_top import cfcr_pkg::*; #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_func,
    input  logic [7:0] i_rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_tx_byte,
    output logic       o_last,
    output logic [1:0] o_status
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    // front to queue
    logic   job_push;
    t_job   job_in;
    // queue to back
    t_job   job_out;
    t_qstat qstat;
    logic   job_pop;
    logic   back_busy;
    // payload store
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;

    // Parse the frame, check the CRC, store payload and post one job per frame
    cfcr_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_func      (i_func),
        .i_rx_byte   (i_rx_byte),
        .i_qstat     (qstat),
        .i_back_busy (back_busy),
        .o_job_push  (job_push),
        .o_job       (job_in),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata)
    );

    // Decouple parsing from reply generation
    cfcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_qstat (qstat)
    );

    // Payload bytes of the current frame
    cfcr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Emit status or the reply frame, one word at a time
    cfcr_back #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (qstat.not_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_busy      (back_busy),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_tx_byte   (o_tx_byte),
        .o_last      (o_last),
        .o_status    (o_status)
    );

endmodule
